FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, compiled out in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/wfr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_pkg
// Shared widths, reset values and the CRC-8 byte update of the frame receiver.
// ---------------------------------------------------------------------------
package wfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int ADDR_W     = 7;
  localparam int CMD_W      = 7;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register reset values.
  localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 7'd1;
  localparam logic [BYTE_W-1:0] FEND_RST     = 8'd192;
  localparam logic [BYTE_W-1:0] FESC_RST     = 8'd219;
  localparam logic [BYTE_W-1:0] TFEND_RST    = 8'd220;
  localparam logic [BYTE_W-1:0] TFESC_RST    = 8'd221;
  localparam logic [BYTE_W-1:0] CRC_SEED_RST = 8'd222;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FESC     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TFEND    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TFESC    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED = 3'd5;

  // Event codes carried in event_kind.
  typedef enum logic [KIND_W-1:0] {
    EV_DATA    = 3'd0,
    EV_GOOD    = 3'd1,
    EV_BAD_ESC = 3'd2,
    EV_BAD_CMD = 3'd3,
    EV_BAD_LEN = 3'd4,
    EV_BAD_CRC = 3'd5
  } ev_kind_t;

  // Reflected Dallas CRC-8 constants.
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h18;
  localparam logic [BYTE_W-1:0] CRC_TOP  = 8'h80;

  // One byte through the CRC, least significant bit first.
  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] din);
    logic [BYTE_W-1:0] c;
    logic [BYTE_W-1:0] d;
    c = crc;
    d = din;
    for (int i = 0; i < BYTE_W; i++) begin
      if ((d[0] ^ c[0]) == 1'b1) begin
        c = ((c ^ CRC_POLY) >> 1) | CRC_TOP;
      end else begin
        c = c >> 1;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

FILE: sv/wfr_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfr_if
// Valid/ready channels of the frame receiver: raw bytes in, events out.
// ---------------------------------------------------------------------------
interface wfr_in_if;
  import wfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface wfr_out_if;
  import wfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [CMD_W-1:0]  command_code;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] payload_index;
  logic [BYTE_W-1:0] payload_length;

  modport source (output valid, output event_kind, output command_code,
                  output payload_byte, output payload_index,
                  output payload_length, input ready);
  modport sink   (input valid, input event_kind, input command_code,
                  input payload_byte, input payload_index,
                  input payload_length, output ready);
endinterface

FILE: sv/wake_frame_receiver.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wake_frame_receiver
// Serial frame receiver: unstuffing, address filter, length check, CRC-8.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Word contents
//  -------  ---------  -----------------------------------------------------
//  in_ch    sink       rx_byte: one raw byte from the serial line
//  out_ch   source     event_kind, command_code, payload_byte,
//                      payload_index, payload_length
//  cfg_*    write      cfg_we, cfg_index, cfg_wdata (no read-back)
//
//  A word is taken into an input register and then processed by the frame
//  state logic, which loads an event into the output register.
//  One word per cycle is sustained while out_ch is ready; the event of a word
//  reaches out_ch through the input register and then the output register.
//  The input register advances whenever the output register is empty or
//  being drained, so in_ch.ready follows out_ch.ready.
//  Reset (rst_n low at a clock edge) restores register defaults and waits
//  for a frame-end word.
//
`include "assert_macros.svh"

module wake_frame_receiver #(
  parameter int MAX_PAYLOAD = 255
) (
  input  logic                             clk,
  input  logic                             rst_n,
  wfr_in_if.sink                           in_ch,
  wfr_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [wfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wfr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wfr_pkg::*;

  localparam logic [BYTE_W-1:0] MaxLen = BYTE_W'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_WAIT_END = 3'd0,
    PH_ADDR     = 3'd1,
    PH_CMD      = 3'd2,
    PH_LEN      = 3'd3,
    PH_DATA     = 3'd4
  } phase_t;

  // Configuration registers.
  logic [ADDR_W-1:0] own_addr_r;
  logic [BYTE_W-1:0] fend_r, fesc_r, tfend_r, tfesc_r, crc_seed_r;

  // Input register.
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;

  // Frame state.
  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] prev_r, prev_nxt;
  logic [BYTE_W-1:0] crc_r, crc_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] ptr_r, ptr_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;

  // Result of the current word.
  logic              res_vld;
  ev_kind_t          res_kind;
  logic [CMD_W-1:0]  res_cmd;
  logic [BYTE_W-1:0] res_byte, res_idx, res_len;

  // Output register.
  logic              out_vld_r;
  ev_kind_t          out_kind_r;
  logic [CMD_W-1:0]  out_cmd_r;
  logic [BYTE_W-1:0] out_byte_r, out_idx_r, out_len_r;

  logic advance;
  logic step;

  // The processing stage moves when the output register can take a word.
  assign advance     = !out_vld_r || out_ch.ready;
  assign step        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= OWN_ADDR_RST;
      fend_r     <= FEND_RST;
      fesc_r     <= FESC_RST;
      tfend_r    <= TFEND_RST;
      tfesc_r    <= TFESC_RST;
      crc_seed_r <= CRC_SEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OWN_ADDR: own_addr_r <= cfg_wdata[ADDR_W-1:0];
        REG_FEND:     fend_r     <= cfg_wdata;
        REG_FESC:     fesc_r     <= cfg_wdata;
        REG_TFEND:    tfend_r    <= cfg_wdata;
        REG_TFESC:    tfesc_r    <= cfg_wdata;
        REG_CRC_SEED: crc_seed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame decoding of the word in the input register.
  always_comb begin
    logic [BYTE_W-1:0] dec;
    logic [ADDR_W-1:0] addr;
    logic              done;
    phase_t            ph;

    phase_nxt = phase_r;
    prev_nxt  = prev_r;
    crc_nxt   = crc_r;
    cmd_nxt   = cmd_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b0;
    res_kind  = EV_DATA;
    res_cmd   = '0;
    res_byte  = '0;
    res_idx   = '0;
    res_len   = '0;
    dec       = in_byte_r;
    addr      = in_byte_r[ADDR_W-1:0];
    done      = 1'b0;
    ph        = phase_r;

    if (in_byte_r == fend_r) begin
      // A frame-end word restarts the frame from any phase.
      prev_nxt  = in_byte_r;
      crc_nxt   = crc8_feed(crc_seed_r, in_byte_r);
      phase_nxt = PH_ADDR;
    end else if (phase_r != PH_WAIT_END) begin
      prev_nxt = in_byte_r;
      if (prev_r == fesc_r) begin
        if (in_byte_r == tfesc_r) begin
          dec = fesc_r;
        end else if (in_byte_r == tfend_r) begin
          dec = fend_r;
        end else begin
          phase_nxt = PH_WAIT_END;
          res_vld   = 1'b1;
          res_kind  = EV_BAD_ESC;
          done      = 1'b1;
        end
      end else if (in_byte_r == fesc_r) begin
        // Lone escape: only remembered in the history.
        done = 1'b1;
      end

      addr = dec[ADDR_W-1:0];
      if (!done && phase_r == PH_ADDR) begin
        if (dec[BYTE_W-1]) begin
          if (addr == '0 || addr == own_addr_r) begin
            crc_nxt   = crc8_feed(crc_r, {1'b0, addr});
            phase_nxt = PH_CMD;
          end else begin
            phase_nxt = PH_WAIT_END;
          end
          done = 1'b1;
        end else begin
          // No address word: this one is already the command.
          ph = PH_CMD;
        end
      end

      if (!done) begin
        unique case (ph)
          PH_CMD: begin
            if (dec[BYTE_W-1]) begin
              phase_nxt = PH_WAIT_END;
              res_vld   = 1'b1;
              res_kind  = EV_BAD_CMD;
            end else begin
              cmd_nxt   = dec[CMD_W-1:0];
              crc_nxt   = crc8_feed(crc_r, dec);
              phase_nxt = PH_LEN;
            end
          end
          PH_LEN: begin
            if (dec > MaxLen) begin
              phase_nxt = PH_WAIT_END;
              res_vld   = 1'b1;
              res_kind  = EV_BAD_LEN;
            end else begin
              cnt_nxt   = dec;
              crc_nxt   = crc8_feed(crc_r, dec);
              ptr_nxt   = '0;
              phase_nxt = PH_DATA;
            end
          end
          PH_DATA: begin
            res_vld = 1'b1;
            res_len = cnt_r;
            if (ptr_r < cnt_r) begin
              ptr_nxt  = ptr_r + 8'd1;
              crc_nxt  = crc8_feed(crc_r, dec);
              res_kind = EV_DATA;
              res_byte = dec;
              res_idx  = ptr_r;
            end else begin
              phase_nxt = PH_WAIT_END;
              if (dec != crc_r) begin
                res_kind = EV_BAD_CRC;
              end else begin
                res_kind = EV_GOOD;
                res_cmd  = cmd_r;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Input register, frame state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_WAIT_END;
      prev_r    <= '0;
      crc_r     <= '0;
      cmd_r     <= '0;
      ptr_r     <= '0;
      cnt_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (advance) begin
        out_vld_r <= step && res_vld;
      end
      if (step) begin
        phase_r <= phase_nxt;
        prev_r  <= prev_nxt;
        crc_r   <= crc_nxt;
        cmd_r   <= cmd_nxt;
        ptr_r   <= ptr_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (step && res_vld) begin
      out_kind_r <= res_kind;
      out_cmd_r  <= res_cmd;
      out_byte_r <= res_byte;
      out_idx_r  <= res_idx;
      out_len_r  <= res_len;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.event_kind     = out_kind_r;
  assign out_ch.command_code   = out_cmd_r;
  assign out_ch.payload_byte   = out_byte_r;
  assign out_ch.payload_index  = out_idx_r;
  assign out_ch.payload_length = out_len_r;

  // A stalled word in the input register must not change or disappear.
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_r && !advance,
               in_vld_r && $stable(in_byte_r), "input register lost a stalled word")
  // A frame-end word always opens the address phase.
  `ASSERT_NEXT(a_fend_restart, clk, rst_n, step && in_byte_r == fend_r,
               phase_r == PH_ADDR, "frame end did not restart the frame")
  // Each data event moves the payload pointer on by one.
  `ASSERT_NEXT(a_ptr_step, clk, rst_n, step && res_vld && res_kind == EV_DATA,
               ptr_r == $past(ptr_r) + 8'd1, "payload pointer did not advance")
  // Data events never run past the declared length.
  `ASSERT_IMPL(a_idx_range, clk, rst_n, out_vld_r && out_kind_r == EV_DATA,
               out_idx_r < out_len_r, "data index beyond declared length")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the serial frame receiver.
// A byte-level model follows every accepted word and predicts the event
// it raises. Each event the receiver hands out is matched against the
// oldest prediction, field by field. Traffic is mostly framed, stuffed and
// checksummed, with random content, plus damaged frames and line noise.
// It runs under several register settings and several idling patterns.
// ---------------------------------------------------------------------------
module tb;
  import wfr_pkg::*;

  // Register indexes beyond the last register. They do not exist in the
  // block, so writes to them must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  // Where the receiver stands inside a frame.
  typedef enum logic [2:0] {
    PH_WAIT_END = 3'd0,
    PH_ADDR     = 3'd1,
    PH_CMD      = 3'd2,
    PH_LEN      = 3'd3,
    PH_DATA     = 3'd4
  } rx_phase_t;

  // How a generated frame is addressed and how it is damaged.
  typedef enum int {ADDR_NONE, ADDR_OWN, ADDR_BROADCAST, ADDR_OTHER} addr_mode_t;
  typedef enum int {FL_NONE, FL_BAD_CRC, FL_BAD_ESCAPE, FL_CMD_BIT7, FL_TRUNCATE} frame_flaw_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] length;
  } rx_event_t;

  localparam int SETTLE_CYCLES = 8;     // pipeline depth plus margin
  localparam int STALL_LIMIT   = 4000;  // cycles without a handshake on either channel
  localparam int PHASE_WORDS   = 80;
  localparam int LONG_HOLD     = 200;

  // -------------------------------------------------------------------------
  // Predictor and checker of the receiver's events.
  // -------------------------------------------------------------------------
  class frame_event_checker;
    localparam int MAX_LEN = 255;

    bit [ADDR_W-1:0] own;
    bit [BYTE_W-1:0] fend, esc, tfend, tfesc, seed;
    rx_phase_t       phase;
    bit [BYTE_W-1:0] last_raw, crc, ptr, count;
    bit [CMD_W-1:0]  held_cmd;
    rx_event_t       due_events[$];
    int              errors;

    function new();
      own      = OWN_ADDR_RST;
      fend     = FEND_RST;
      esc      = FESC_RST;
      tfend    = TFEND_RST;
      tfesc    = TFESC_RST;
      seed     = CRC_SEED_RST;
      phase    = PH_WAIT_END;
      last_raw = '0;
      crc      = '0;
      ptr      = '0;
      count    = '0;
      held_cmd = '0;
      errors   = 0;
    endfunction

    // Reflected Dallas CRC-8, one byte, low bit first.
    static function bit [BYTE_W-1:0] crc_step(bit [BYTE_W-1:0] c_in, bit [BYTE_W-1:0] d_in);
      bit [BYTE_W-1:0] c, d;
      c = c_in;
      d = d_in;
      for (int i = 0; i < BYTE_W; i++) begin
        if (c[0] ^ d[0]) begin
          c = {1'b1, c[7:1] ^ 7'h0C};
        end else begin
          c = {1'b0, c[7:1]};
        end
        d = d >> 1;
      end
      return c;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] v);
      case (idx)
        REG_OWN_ADDR: own   = v[ADDR_W-1:0];
        REG_FEND:     fend  = v;
        REG_FESC:     esc   = v;
        REG_TFEND:    tfend = v;
        REG_TFESC:    tfesc = v;
        REG_CRC_SEED: seed  = v;
        default: ;
      endcase
    endfunction

    function void post(ev_kind_t k, bit [CMD_W-1:0] c, bit [BYTE_W-1:0] d,
                       bit [BYTE_W-1:0] i, bit [BYTE_W-1:0] l);
      rx_event_t e;
      e.kind    = k;
      e.command = c;
      e.data    = d;
      e.index   = i;
      e.length  = l;
      due_events.push_back(e);
    endfunction

    // Follows one accepted word and queues the event it raises, if any.
    function void take_byte(bit [BYTE_W-1:0] raw);
      bit [BYTE_W-1:0] b, last;
      b = raw;
      // A frame-end word restarts the frame from any phase.
      if (b == fend) begin
        last_raw = b;
        crc      = crc_step(seed, b);
        phase    = PH_ADDR;
        return;
      end
      if (phase == PH_WAIT_END) return;
      // The escape history keeps the raw word, not the decoded one.
      last     = last_raw;
      last_raw = b;
      if (last == esc) begin
        // The escaped escape code wins when both codes are equal.
        if (b == tfesc) begin
          b = esc;
        end else if (b == tfend) begin
          b = fend;
        end else begin
          phase = PH_WAIT_END;
          post(EV_BAD_ESC, '0, '0, '0, '0);
          return;
        end
      end else if (b == esc) begin
        return;
      end
      if (phase == PH_ADDR) begin
        if (b[7]) begin
          // Foreign addresses drop the frame without any event.
          if (b[6:0] == 7'd0 || b[6:0] == own) begin
            crc   = crc_step(crc, {1'b0, b[6:0]});
            phase = PH_CMD;
          end else begin
            phase = PH_WAIT_END;
          end
          return;
        end
        phase = PH_CMD;
      end
      case (phase)
        PH_CMD: begin
          if (b[7]) begin
            phase = PH_WAIT_END;
            post(EV_BAD_CMD, '0, '0, '0, '0);
          end else begin
            held_cmd = b[6:0];
            crc      = crc_step(crc, b);
            phase    = PH_LEN;
          end
        end
        PH_LEN: begin
          if (int'(b) > MAX_LEN) begin
            phase = PH_WAIT_END;
            post(EV_BAD_LEN, '0, '0, '0, '0);
          end else begin
            count = b;
            crc   = crc_step(crc, b);
            ptr   = '0;
            phase = PH_DATA;
          end
        end
        PH_DATA: begin
          if (ptr < count) begin
            post(EV_DATA, '0, b, ptr, count);
            ptr = ptr + 8'd1;
            crc = crc_step(crc, b);
          end else begin
            phase = PH_WAIT_END;
            if (b != crc) begin
              post(EV_BAD_CRC, '0, '0, '0, count);
            end else begin
              post(EV_GOOD, held_cmd, '0, '0, count);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void match_event(rx_event_t got);
      rx_event_t want;
      if (due_events.size() == 0) begin
        errors++;
        $error("event_kind: expected no event, got %0d", got.kind);
        return;
      end
      want = due_events.pop_front();
      compare("event_kind", BYTE_W'(want.kind), BYTE_W'(got.kind));
      compare("command_code", BYTE_W'(want.command), BYTE_W'(got.command));
      compare("payload_byte", want.data, got.data);
      compare("payload_index", want.index, got.index);
      compare("payload_length", want.length, got.length);
    endfunction

    function int pending();
      return due_events.size();
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, channels and the block under test.
  // -------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wfr_in_if  in_ch();
  wfr_out_if out_ch();

  wake_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  frame_event_checker checker_h = new();

  // The generator keeps its own copy of the codes, so that it can stuff
  // and checksum frames the way the current setting expects them.
  bit [ADDR_W-1:0] g_own   = OWN_ADDR_RST;
  bit [BYTE_W-1:0] g_fend  = FEND_RST;
  bit [BYTE_W-1:0] g_esc   = FESC_RST;
  bit [BYTE_W-1:0] g_tfend = TFEND_RST;
  bit [BYTE_W-1:0] g_tfesc = TFESC_RST;
  bit [BYTE_W-1:0] g_seed  = CRC_SEED_RST;

  int tx_idle_pct   = 0;   // chance per cycle that the sender holds back a word
  int rx_stall_pct  = 0;   // chance per cycle that the receiver drops ready
  int hold_requests = 0;   // bumped by the stimulus to ask for a long hold-off
  int words_sent    = 0;   // framed words only, line noise is not counted
  int quiet_cycles  = 0;

  // -------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, before the block and
  // the drivers update their outputs for the next cycle.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    rx_event_t got;
    if (rst_n) begin
      if (cfg_we) checker_h.write_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) checker_h.take_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        got.kind    = ev_kind_t'(out_ch.event_kind);
        got.command = out_ch.command_code;
        got.data    = out_ch.payload_byte;
        got.index   = out_ch.payload_index;
        got.length  = out_ch.payload_length;
        checker_h.match_event(got);
      end
      // Watchdog: a healthy run never goes this long without a handshake.
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Event sink. Ready is random per cycle; on request it is held low for a
  // long stretch so the block fills up and pushes back on its input.
  // -------------------------------------------------------------------------
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Drivers. Every task is entered just after a rising edge and returns just
  // after one.
  // -------------------------------------------------------------------------

  // Offers one word and waits until the block takes it.
  task automatic send_byte(input bit [BYTE_W-1:0] b, input bit framed);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (framed) words_sent++;
  endtask

  // Stops sending until every predicted event has come out, then lets the
  // pipeline empty of words that raise no event.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all six registers back to back; only called while idle.
  task automatic apply_config(input bit [ADDR_W-1:0] own, input bit [BYTE_W-1:0] fend,
                              input bit [BYTE_W-1:0] esc, input bit [BYTE_W-1:0] tfend,
                              input bit [BYTE_W-1:0] tfesc, input bit [BYTE_W-1:0] seed,
                              input bit touch_spare);
    bit [CFG_DATA_W-1:0]  vals[6];
    logic [CFG_IDX_W-1:0] regs[6];
    regs = '{REG_OWN_ADDR, REG_FEND, REG_FESC, REG_TFEND, REG_TFESC, REG_CRC_SEED};
    // The top bit of the address write is don't-care; exercise it anyway.
    vals = '{{1'($urandom_range(1)), own}, fend, esc, tfend, tfesc, seed};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    if (touch_spare) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_SPARE_A;
      cfg_wdata <= 8'hA5;
      @(posedge clk);
      cfg_index <= REG_SPARE_B;
      cfg_wdata <= 8'h5A;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    g_own   = own;
    g_fend  = fend;
    g_esc   = esc;
    g_tfend = tfend;
    g_tfesc = tfesc;
    g_seed  = seed;
  endtask

  // Builds one frame under the current codes, stuffs it, damages it as asked
  // and sends it. With special_data the payload alternates the frame-end and
  // escape values so that both stuffing sequences show up.
  task automatic send_frame(input addr_mode_t amode, input bit [BYTE_W-1:0] cmd,
                            input int len, input frame_flaw_t flaw, input bit special_data);
    bit [BYTE_W-1:0] logical[$];
    bit [BYTE_W-1:0] raw[$];
    bit [BYTE_W-1:0] crc, d, bad;
    bit [ADDR_W-1:0] a;
    int              cut;
    crc = frame_event_checker::crc_step(g_seed, g_fend);
    if (flaw == FL_CMD_BIT7) begin
      // Without an address the flagged command would be taken for one.
      cmd[7] = 1'b1;
      if (amode == ADDR_NONE) amode = ADDR_OWN;
    end
    if (amode != ADDR_NONE) begin
      case (amode)
        ADDR_OWN:       a = g_own;
        ADDR_BROADCAST: a = '0;
        default: begin
          do a = ADDR_W'($urandom_range(1, 127)); while (a == g_own);
        end
      endcase
      logical.push_back({1'b1, a});
      crc = frame_event_checker::crc_step(crc, {1'b0, a});
    end
    logical.push_back(cmd);
    crc = frame_event_checker::crc_step(crc, cmd);
    logical.push_back(BYTE_W'(len));
    crc = frame_event_checker::crc_step(crc, BYTE_W'(len));
    for (int i = 0; i < len; i++) begin
      if (special_data) begin
        d = (i % 2 == 0) ? g_fend : g_esc;
      end else if ($urandom_range(99) < 12) begin
        d = $urandom_range(1) ? g_fend : g_esc;
      end else begin
        d = BYTE_W'($urandom_range(255));
      end
      logical.push_back(d);
      crc = frame_event_checker::crc_step(crc, d);
    end
    if (flaw == FL_BAD_CRC) crc = crc ^ BYTE_W'($urandom_range(1, 255));
    logical.push_back(crc);

    raw.push_back(g_fend);
    foreach (logical[i]) begin
      if (logical[i] == g_fend) begin
        raw.push_back(g_esc);
        raw.push_back(g_tfend);
      end else if (logical[i] == g_esc) begin
        raw.push_back(g_esc);
        raw.push_back(g_tfesc);
      end else begin
        raw.push_back(logical[i]);
      end
    end

    if (flaw == FL_BAD_ESCAPE) begin
      // Cut the frame somewhere after its start and end it on an escape
      // followed by a word that is neither transposed code.
      cut = $urandom_range(1, raw.size() - 1);
      while (raw.size() > cut) void'(raw.pop_back());
      do bad = BYTE_W'($urandom_range(255));
      while (bad == g_tfend || bad == g_tfesc || bad == g_fend);
      raw.push_back(g_esc);
      raw.push_back(bad);
    end else if (flaw == FL_TRUNCATE) begin
      cut = $urandom_range(1, raw.size() - 1);
      while (raw.size() > cut) void'(raw.pop_back());
    end

    foreach (raw[i]) send_byte(raw[i], 1'b1);
  endtask

  // A short burst of line noise between frames.
  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_byte(BYTE_W'($urandom_range(255)), 1'b0);
  endtask

  task automatic send_random_frame(input int len_override);
    int          r;
    int          len;
    addr_mode_t  amode;
    frame_flaw_t flaw;
    r = $urandom_range(99);
    if (r < 72)      flaw = FL_NONE;
    else if (r < 81) flaw = FL_BAD_CRC;
    else if (r < 88) flaw = FL_BAD_ESCAPE;
    else if (r < 94) flaw = FL_CMD_BIT7;
    else             flaw = FL_TRUNCATE;
    r = $urandom_range(99);
    if (r < 30)      amode = ADDR_NONE;
    else if (r < 65) amode = ADDR_OWN;
    else if (r < 90) amode = ADDR_BROADCAST;
    else             amode = ADDR_OTHER;
    if (len_override > 0) begin
      len = len_override;
    end else if ($urandom_range(99) < 85) begin
      len = $urandom_range(0, 6);
    end else begin
      len = $urandom_range(7, 40);
    end
    send_frame(amode, BYTE_W'($urandom_range(127)), len, flaw, 1'b0);
  endtask

  // One phase of random traffic. Half way through the sender waits for the
  // block to run dry; optionally the sink takes a long break early on while
  // the sender keeps pushing, and optionally one frame is long.
  task automatic run_traffic(input int budget, input bit with_hold, input int long_len);
    int  start;
    bit  paused, held, long_done;
    start     = words_sent;
    paused    = 1'b0;
    held      = 1'b0;
    long_done = (long_len == 0);
    while (words_sent - start < budget) begin
      if (with_hold && !held && words_sent - start >= budget / 4) begin
        held = 1'b1;
        hold_requests++;
      end
      if (!paused && words_sent - start >= budget / 2) begin
        paused = 1'b1;
        drain();
      end
      if ($urandom_range(9) == 0) send_noise();
      if (!long_done && words_sent - start >= budget / 3) begin
        long_done = 1'b1;
        send_random_frame(long_len);
      end else begin
        send_random_frame(0);
      end
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      1: begin
        tx_idle_pct  = 69;
        rx_stall_pct = 0;
      end
      2: begin
        tx_idle_pct  = 0;
        rx_stall_pct = 69;
      end
      default: begin
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
      end
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Main sequence.
  // -------------------------------------------------------------------------
  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_OWN_ADDR;
    cfg_wdata     <= '0;
    rst_n         <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset codes: idle noise at both extremes, a
    // bare good frame, an addressed frame whose payload needs both escapes,
    // a broadcast frame with a wrong checksum, a frame for someone else,
    // a command with its top bit set and a broken escape.
    set_idling(0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame(ADDR_NONE, 8'h00, 0, FL_NONE, 1'b0);
    send_frame(ADDR_OWN, 8'h7F, 2, FL_NONE, 1'b1);
    send_frame(ADDR_BROADCAST, 8'h05, 1, FL_BAD_CRC, 1'b0);
    send_frame(ADDR_OTHER, 8'h11, 0, FL_NONE, 1'b0);
    send_frame(ADDR_OWN, 8'h10, 0, FL_CMD_BIT7, 1'b0);
    send_frame(ADDR_NONE, 8'h22, 3, FL_BAD_ESCAPE, 1'b0);

    // Random phases, each under its own setting and idling pattern.
    for (int ph = 1; ph <= 9; ph++) begin
      drain();
      case (ph)
        // Highest address, zero seed; also pokes the two unused indexes.
        1: apply_config(7'd127, 8'hC0, 8'hDB, 8'hDC, 8'hDD, 8'h00, 1'b1);
        // Codes at the bottom and top of the byte range.
        2: apply_config(7'd1, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 1'b0);
        3: apply_config(ADDR_W'($urandom_range(1, 127)), 8'hFF, 8'h00, 8'h80, 8'h7F,
                        BYTE_W'($urandom_range(255)), 1'b0);
        // Both transposed codes equal: escaped words always decode to escape.
        4: apply_config(7'd42, 8'h7E, 8'h7D, 8'h5E, 8'h5E, 8'h5A, 1'b0);
        default: begin
          apply_config(ADDR_W'($urandom_range(1, 127)), BYTE_W'($urandom_range(255)),
                       BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                       BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)), 1'b0);
        end
      endcase
      set_idling(ph % 4);
      run_traffic(PHASE_WORDS, ph == 4, (ph == 3) ? 255 : (ph == 7) ? $urandom_range(128, 200) : 0);
    end

    drain();
    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
